// ===== design/dwo_pkg.sv =====
// types and constants shared by the wheel odometry block
// no dependencies

package dwo_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPD1,
		ST_SPD2,
		ST_SPD3,
		ST_CHECK,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_CORD,
		ST_P5,
		ST_P6,
		ST_DIV1,
		ST_DIV2,
		ST_OUT
	} state_t;

	localparam logic [1:0] REG_SPEED_PER_RPM  = 2'd0;
	localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd1;
	localparam logic [1:0] REG_SPEED_DEADBAND = 2'd2;

	localparam logic [28:0] ID_LEFT  = 29'h503;
	localparam logic [28:0] ID_RIGHT = 29'h502;
	localparam logic [3:0]  DLC_FULL = 4'd8;

	localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
	localparam logic [32:0] CORDIC_GAIN_Q30 = 33'd652032874;
	localparam logic [31:0] SAT_MAX         = 32'h7FFF_FFFF;

	// atan(2^-i) as binary angle, full turn = 2^32
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/dwo_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on dwo_pkg (gain, arctangent table)

module dwo_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [32:0] cos_out,
	output logic signed [32:0] sin_out
);

	logic signed [32:0] x_q, y_q, z_q;
	logic signed [32:0] xs, ys, at;
	logic [4:0]         i_q;
	logic               busy_q, done_q, flip_q;
	logic               flip;
	logic [31:0]        folded;

	assign flip   = angle[31] ^ angle[30];
	assign folded = flip ? angle + 32'h8000_0000 : angle;
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign at     = {1'b0, dwo_pkg::atan_bam(i_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == 5'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= dwo_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= {folded[31], folded};
			i_q    <= '0;
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			i_q <= i_q + 5'd1;
		end
	end

	assign done    = done_q;
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;

endmodule

// ===== design/dwo_div.sv =====
// restoring divider, one quotient bit per cycle, rounded and saturated result
// computes min(2^31-1, round(num * 2^K / den)); no package dependency

module dwo_div #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 49,
	parameter int K     = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [31:0]      res
);

	localparam int NW    = NUM_W + K;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    n_q;
	logic [DEN_W-1:0] r_q, den_q;
	logic [31:0]      q_q;
	logic             ovf_q, busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rs, rdiff;
	logic             ge, rnd;

	assign rs    = {r_q, n_q[NW-1]};
	assign ge    = rs >= {1'b0, den_q};
	assign rdiff = rs - {1'b0, den_q};
	assign rnd   = {r_q, 1'b0} >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= NW'(num) << K;
			den_q <= den;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			cnt_q <= CNT_W'(NW);
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			r_q   <= ge ? rdiff[DEN_W-1:0] : rs[DEN_W-1:0];
			q_q   <= {q_q[30:0], ge};
			ovf_q <= ovf_q | q_q[31];
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		if (ovf_q || q_q[31] || (rnd && q_q == 32'h7FFF_FFFF))
			res = 32'h7FFF_FFFF;
		else
			res = q_q + 32'(rnd);
	end

	assign done = done_q;

endmodule

// ===== design/differential_wheel_odometry_top.sv =====
// wheel odometry from received can frames: sequencer, shared multiplier, pose state
// depends on dwo_pkg, dwo_cordic, dwo_div

// A frame that is ignored (wrong id, remote, extended, bad length, wheel already
// used, or any frame once halted) is taken while the sequencer stays idle. A wheel
// frame that is used runs the states SPD1, SPD2, SPD3 and CHECK, using the shared
// 34x34 multiplier (SPD3 is skipped when the wheel speed falls in the deadband).
// When it completes a pair, the pose update runs the sequencer states, waits on
// the cordic and makes two passes of the bit-serial divider before out_valid
// rises; a zero interval sum skips the divider.
// The input is stalled from acceptance of a used frame until the sequencer is
// idle again, which after a pair is when the result transaction completes.
// An error frame halts the block until reset.

module differential_wheel_odometry_top #(
	parameter int CORDIC_STEPS       = 16,
	parameter int TIME_FRACTION_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [28:0]        can_id,
	input  logic               is_extended,
	input  logic               is_remote,
	input  logic               is_error,
	input  logic [3:0]         data_length,
	input  logic [7:0]         rpm_low_byte,
	input  logic [7:0]         rpm_high_byte,
	input  logic [31:0]        timestamp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] odom_x,
	output logic signed [31:0] odom_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] linear_speed,
	output logic signed [31:0] angular_rate,
	output logic signed [31:0] distance_travelled
);

	localparam int TFB   = TIME_FRACTION_BITS;
	localparam int NUM_W = 57;
	localparam int DEN_W = 49;

	dwo_pkg::state_t state_q, state_d;

	logic [23:0] spr_q, iwb_q;
	logic [15:0] db_q;
	logic        halted_q, left_armed_q, right_armed_q, wheel_left_q;
	logic [31:0] left_last_q, right_last_q, left_int_q, right_int_q;
	logic [31:0] left_step_q, right_step_q;
	logic [31:0] px_q, py_q, hd_q, trav_q, lin_q, ang_q, dtheta_q;
	logic [15:0] raw_q;
	logic signed [67:0] prod_q;
	logic [56:0] p_q;
	logic [55:0] hi_q;
	logic signed [32:0] ds_q;
	logic        dneg_q;

	logic signed [33:0] mul_a, mul_b;
	logic        acc, frame_ok, is_left, use_frame;
	logic [15:0] rpm_mag;
	logic [31:0] spd, int_sel;
	logic [64:0] st_round, st;
	logic [31:0] step_mag, step_val;
	logic signed [32:0] sum, sum_adj, ds, diff;
	logic [32:0] dmag, ds_mag;
	logic [56:0] amag;
	logic [31:0] half;
	logic signed [67:0] rot_round;
	logic [32:0] sden;
	logic        cor_start, cor_done, div_start, div_done;
	logic signed [32:0] cos_v, sin_v;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [31:0] div_res;

	// frame decode at the input transaction
	assign acc      = in_valid && !in_stall;
	assign is_left  = can_id == dwo_pkg::ID_LEFT;
	assign frame_ok = !halted_q && !is_error && !is_remote && !is_extended
		&& data_length == dwo_pkg::DLC_FULL
		&& (is_left || can_id == dwo_pkg::ID_RIGHT);
	assign use_frame = frame_ok && (is_left ? left_armed_q : right_armed_q);

	// wheel step arithmetic
	assign rpm_mag  = raw_q[15] ? 16'(17'h10000 - {1'b0, raw_q}) : raw_q;
	assign spd      = 32'((prod_q[39:0] + 40'd128) >> 8);
	assign int_sel  = wheel_left_q ? left_int_q : right_int_q;
	assign st_round = {1'b0, prod_q[63:0]} + (65'd1 << (TFB - 1));
	assign st       = st_round >> TFB;
	assign step_mag = (st > 65'(dwo_pkg::SAT_MAX)) ? dwo_pkg::SAT_MAX : st[31:0];
	assign step_val = raw_q[15] ? -step_mag : step_mag;

	// pose arithmetic
	assign sum     = {left_step_q[31], left_step_q} + {right_step_q[31], right_step_q};
	assign sum_adj = sum + 33'(sum[32]);
	assign ds      = sum_adj >>> 1;
	assign diff    = {right_step_q[31], right_step_q} - {left_step_q[31], left_step_q};
	assign dmag    = diff[32] ? 33'(-diff) : 33'(diff);
	assign amag    = {1'b0, hi_q} + 57'((prod_q[61:0] + 62'h8000_0000) >> 32);
	assign half    = dneg_q ? -amag[32:1] : amag[32:1];
	assign rot_round = prod_q + 68'sd536870912;
	assign sden    = {1'b0, left_int_q} + {1'b0, right_int_q};
	assign ds_mag  = ds_q[32] ? 33'(-ds_q) : 33'(ds_q);

	assign div_num = (state_q == dwo_pkg::ST_P6) ? NUM_W'(ds_mag) : p_q;
	assign div_den = (state_q == dwo_pkg::ST_P6) ? DEN_W'(sden) : {sden, 16'b0};

	dwo_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (hd_q + half),
		.done    (cor_done),
		.cos_out (cos_v),
		.sin_out (sin_v)
	);

	dwo_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.K    (TFB + 1)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dwo_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cor_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			dwo_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && use_frame)
					state_d = dwo_pkg::ST_SPD1;
			end
			dwo_pkg::ST_SPD1: begin
				mul_a   = 34'(rpm_mag);
				mul_b   = 34'(spr_q);
				state_d = dwo_pkg::ST_SPD2;
			end
			dwo_pkg::ST_SPD2: begin
				mul_a   = 34'(spd);
				mul_b   = 34'(int_sel);
				state_d = (spd <= 32'(db_q)) ? dwo_pkg::ST_CHECK : dwo_pkg::ST_SPD3;
			end
			dwo_pkg::ST_SPD3: state_d = dwo_pkg::ST_CHECK;
			dwo_pkg::ST_CHECK:
				state_d = (!left_armed_q && !right_armed_q) ? dwo_pkg::ST_P0
					: dwo_pkg::ST_IDLE;
			dwo_pkg::ST_P0: begin
				mul_a   = 34'(dmag);
				mul_b   = 34'(iwb_q);
				state_d = dwo_pkg::ST_P1;
			end
			dwo_pkg::ST_P1: begin
				mul_a   = 34'(prod_q[56:32]);
				mul_b   = 34'(dwo_pkg::INV_TWO_PI_Q32);
				state_d = dwo_pkg::ST_P2;
			end
			dwo_pkg::ST_P2: begin
				mul_a   = 34'(p_q[31:0]);
				mul_b   = 34'(dwo_pkg::INV_TWO_PI_Q32);
				state_d = dwo_pkg::ST_P3;
			end
			dwo_pkg::ST_P3: begin
				cor_start = 1'b1;
				state_d   = dwo_pkg::ST_CORD;
			end
			dwo_pkg::ST_CORD: begin
				mul_a = {ds_q[32], ds_q};
				mul_b = {cos_v[32], cos_v};
				if (cor_done)
					state_d = dwo_pkg::ST_P5;
			end
			dwo_pkg::ST_P5: begin
				mul_a   = {ds_q[32], ds_q};
				mul_b   = {sin_v[32], sin_v};
				state_d = dwo_pkg::ST_P6;
			end
			dwo_pkg::ST_P6: begin
				if (sden == '0) begin
					state_d = dwo_pkg::ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = dwo_pkg::ST_DIV1;
				end
			end
			dwo_pkg::ST_DIV1: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = dwo_pkg::ST_DIV2;
				end
			end
			dwo_pkg::ST_DIV2: begin
				if (div_done)
					state_d = dwo_pkg::ST_OUT;
			end
			dwo_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = dwo_pkg::ST_IDLE;
			end
			default: state_d = dwo_pkg::ST_IDLE;
		endcase
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q      <= 1'b0;
			left_armed_q  <= 1'b1;
			right_armed_q <= 1'b1;
			spr_q         <= 24'd535507;
			iwb_q         <= 24'd63015;
			db_q          <= 16'd655;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					dwo_pkg::REG_SPEED_PER_RPM:  spr_q <= cfg_data;
					dwo_pkg::REG_INV_WHEEL_BASE: iwb_q <= cfg_data;
					dwo_pkg::REG_SPEED_DEADBAND: db_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (acc && !halted_q && is_error)
				halted_q <= 1'b1;
			if (acc && use_frame) begin
				if (is_left)
					left_armed_q <= 1'b0;
				else
					right_armed_q <= 1'b0;
			end
			if (state_q == dwo_pkg::ST_CHECK && !left_armed_q && !right_armed_q) begin
				left_armed_q  <= 1'b1;
				right_armed_q <= 1'b1;
			end
		end
	end

	// odometry state, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_last_q  <= '0;
			right_last_q <= '0;
			left_int_q   <= '0;
			right_int_q  <= '0;
			left_step_q  <= '0;
			right_step_q <= '0;
			px_q         <= '0;
			py_q         <= '0;
			hd_q         <= '0;
			trav_q       <= '0;
		end else begin
			if (acc && use_frame) begin
				if (is_left) begin
					left_int_q  <= timestamp - left_last_q;
					left_last_q <= timestamp;
				end else begin
					right_int_q  <= timestamp - right_last_q;
					right_last_q <= timestamp;
				end
			end
			// deadband gives a zero step
			if (state_q == dwo_pkg::ST_SPD2 && spd <= 32'(db_q)) begin
				if (wheel_left_q)
					left_step_q <= '0;
				else
					right_step_q <= '0;
			end
			if (state_q == dwo_pkg::ST_SPD3) begin
				if (wheel_left_q)
					left_step_q <= step_val;
				else
					right_step_q <= step_val;
			end
			if (state_q == dwo_pkg::ST_P5)
				px_q <= px_q + rot_round[61:30];
			if (state_q == dwo_pkg::ST_P6) begin
				py_q   <= py_q + rot_round[61:30];
				hd_q   <= hd_q + dtheta_q;
				trav_q <= trav_q + ds_q[31:0];
			end
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (acc) begin
			raw_q        <= {rpm_high_byte, rpm_low_byte};
			wheel_left_q <= is_left;
		end
		if (state_q == dwo_pkg::ST_P0) begin
			ds_q   <= ds;
			dneg_q <= diff[32];
		end
		if (state_q == dwo_pkg::ST_P1)
			p_q <= prod_q[56:0];
		if (state_q == dwo_pkg::ST_P2)
			hi_q <= prod_q[55:0];
		if (state_q == dwo_pkg::ST_P3)
			dtheta_q <= dneg_q ? -amag[31:0] : amag[31:0];
		if (state_q == dwo_pkg::ST_P6 && sden == '0) begin
			lin_q <= '0;
			ang_q <= '0;
		end
		if (state_q == dwo_pkg::ST_DIV1 && div_done)
			lin_q <= ds_q[32] ? -div_res : div_res;
		if (state_q == dwo_pkg::ST_DIV2 && div_done)
			ang_q <= dneg_q ? -div_res : div_res;
	end

	assign odom_x             = px_q;
	assign odom_y             = py_q;
	assign heading            = hd_q;
	assign linear_speed       = lin_q;
	assign angular_rate       = ang_q;
	assign distance_travelled = trav_q;

endmodule

// ===== design/dwo_checker.sv =====
// port-level checks for the wheel odometry block, bound to the top level
// no package dependency

module dwo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] odom_x,
	input logic [31:0] heading
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(odom_x) && $stable(heading))
		else $error("stalled result changed");

	// no input taken while a result waits
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted with result pending");

	// one result per pose update
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

	// a result never shows while the input side is open
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> !out_valid || in_stall)
		else $error("result without busy");

endmodule

bind differential_wheel_odometry_top dwo_checker u_dwo_checker (.*);

// ===== dv/tb_differential_wheel_odometry_top.sv =====
// self-checking testbench for the differential wheel odometry block
// depends on dwo_pkg and differential_wheel_odometry_top; predicts each pose update
// from the can frames it sends and checks every result transaction against it

module tb_differential_wheel_odometry_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TFB = 20;
	localparam int STEPS = 16;

	typedef struct {
		logic [28:0] id;
		logic        ext;
		logic        rem;
		logic        err;
		logic [3:0]  dlc;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [31:0] ts;
	} can_frame_t;

	typedef logic [5:0][31:0] pose_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [28:0] can_id = '0;
	logic is_extended = 1'b0;
	logic is_remote = 1'b0;
	logic is_error = 1'b0;
	logic [3:0] data_length = '0;
	logic [7:0] rpm_low_byte = '0;
	logic [7:0] rpm_high_byte = '0;
	logic [31:0] timestamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] odom_x, odom_y, heading;
	logic signed [31:0] linear_speed, angular_rate, distance_travelled;

	differential_wheel_odometry_top dut (.*);

	// predictor state
	logic [31:0] spr_q = 32'd535507, iwb_q = 32'd63015, deadband_q = 32'd655;
	bit halted_q = 0, left_armed_q = 1, right_armed_q = 1;
	logic [31:0] left_last_q = 0, right_last_q = 0, left_ival_q = 0, right_ival_q = 0;
	logic [31:0] left_step_q = 0, right_step_q = 0;
	logic [31:0] x_q = 0, y_q = 0, heading_q = 0, travelled_q = 0;

	pose_t pose_q[$];
	int send_idle = 0, recv_idle = 0;
	int frames_sent = 0, poses_checked = 0, mismatches = 0;
	bit failed = 0;
	logic [31:0] now_ts = 0;

	string field_name[6] = '{"odom_x", "odom_y", "heading",
		"linear_speed", "angular_rate", "distance_travelled"};

	longint unsigned atan_tab[STEPS] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [31:0] wheel_travel(logic [7:0] lo, logic [7:0] hi,
			logic [31:0] ival);
		logic [15:0] raw;
		longint unsigned mag, spd, st;
		raw = {hi, lo};
		mag = raw[15] ? 64'h10000 - raw : raw;
		spd = (mag * spr_q + 128) >> 8;
		if (spd <= deadband_q)
			return 32'd0;
		st = (spd * ival + (64'd1 << (TFB - 1))) >> TFB;
		if (st > 64'h7FFF_FFFF)
			st = 64'h7FFF_FFFF;
		return raw[15] ? 32'(-st) : 32'(st);
	endfunction

	// round(num * 2^k / den) with saturation, long division one bit at a time
	function automatic longint unsigned scaled_quotient(longint unsigned num, int k,
			longint unsigned den);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		if (q > 64'h7FFF_FFFF)
			return 64'h7FFF_FFFF;
		for (int i = 0; i < k; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				q = q | 1;
				r = r - den;
			end
			if (q > 64'h7FFF_FFFF)
				return 64'h7FFF_FFFF;
		end
		if ((r << 1) >= den)
			q++;
		return q > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : q;
	endfunction

	task automatic rotate_heading(input logic [31:0] ang, output longint c, output longint s);
		bit flip;
		longint x, y, z, t;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip)
			ang = ang + 32'h8000_0000;
		x = 652032874;
		y = 0;
		z = longint'(signed'(ang));
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(atan_tab[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(atan_tab[i]);
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input can_frame_t f);
		longint ds, diff, c, s;
		longint unsigned dmag, p, amag, sden, lin, ang;
		logic [31:0] dtheta, half;
		pose_t r;
		bit dneg;
		if (halted_q)
			return;
		if (f.err) begin
			halted_q = 1;
			return;
		end
		if (f.rem || f.ext || (f.id != dwo_pkg::ID_LEFT && f.id != dwo_pkg::ID_RIGHT))
			return;
		if (f.dlc == dwo_pkg::DLC_FULL) begin
			if (f.id == dwo_pkg::ID_LEFT) begin
				if (left_armed_q) begin
					left_ival_q = f.ts - left_last_q;
					left_last_q = f.ts;
					left_step_q = wheel_travel(f.lo, f.hi, left_ival_q);
				end
				left_armed_q = 0;
			end else begin
				if (right_armed_q) begin
					right_ival_q = f.ts - right_last_q;
					right_last_q = f.ts;
					right_step_q = wheel_travel(f.lo, f.hi, right_ival_q);
				end
				right_armed_q = 0;
			end
		end
		if (left_armed_q || right_armed_q)
			return;
		left_armed_q = 1;
		right_armed_q = 1;

		ds = (longint'(signed'(left_step_q)) + longint'(signed'(right_step_q))) / 2;
		diff = longint'(signed'(right_step_q)) - longint'(signed'(left_step_q));
		dneg = diff < 0;
		dmag = dneg ? -diff : diff;
		p = dmag * iwb_q;
		amag = (p >> 32) * 64'd683565276
			+ (((p & 64'hFFFF_FFFF) * 64'd683565276 + 64'h8000_0000) >> 32);
		dtheta = dneg ? 32'(-amag) : 32'(amag);
		half = dneg ? 32'(-(amag >> 1)) : 32'(amag >> 1);

		rotate_heading(heading_q + half, c, s);
		x_q = x_q + 32'((ds * c + (64'sd1 <<< 29)) >>> 30);
		y_q = y_q + 32'((ds * s + (64'sd1 <<< 29)) >>> 30);
		heading_q = heading_q + dtheta;
		travelled_q = travelled_q + 32'(ds);

		sden = longint'(left_ival_q) + longint'(right_ival_q);
		if (sden == 0) begin
			lin = 0;
			ang = 0;
		end else begin
			lin = scaled_quotient(ds < 0 ? -ds : ds, TFB + 1, sden);
			ang = scaled_quotient(p, TFB + 1, sden << 16);
		end
		r[0] = x_q;
		r[1] = y_q;
		r[2] = heading_q;
		r[3] = ds < 0 ? 32'(-lin) : 32'(lin);
		r[4] = dneg ? 32'(-ang) : 32'(ang);
		r[5] = travelled_q;
		pose_q.insert(pose_q.size(), r);
	endtask

	task automatic send_frame(input can_frame_t f);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		can_id <= f.id;
		is_extended <= f.ext;
		is_remote <= f.rem;
		is_error <= f.err;
		data_length <= f.dlc;
		rpm_low_byte <= f.lo;
		rpm_high_byte <= f.hi;
		timestamp <= f.ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pose(f);
		frames_sent++;
	endtask

	// hold the sender until every pose is out and the block has gone quiet
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_config(input logic [23:0] spr, input logic [23:0] iwb,
			input logic [15:0] db);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= dwo_pkg::REG_SPEED_PER_RPM;
		cfg_data <= spr;
		@(posedge clk);
		cfg_index <= dwo_pkg::REG_INV_WHEEL_BASE;
		cfg_data <= iwb;
		@(posedge clk);
		cfg_index <= dwo_pkg::REG_SPEED_DEADBAND;
		cfg_data <= {8'd0, db};
		@(posedge clk);
		cfg_write <= 1'b0;
		spr_q = 32'(spr);
		iwb_q = 32'(iwb);
		deadband_q = 32'(db);
	endtask

	function automatic can_frame_t wheel_frame(bit left, logic [15:0] rpm, logic [31:0] ts);
		can_frame_t f;
		f.id = left ? dwo_pkg::ID_LEFT : dwo_pkg::ID_RIGHT;
		f.ext = 0;
		f.rem = 0;
		f.err = 0;
		f.dlc = dwo_pkg::DLC_FULL;
		{f.hi, f.lo} = rpm;
		f.ts = ts;
		return f;
	endfunction

	function automatic logic [15:0] random_rpm();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($urandom_range(0, 600) - 300);
			2: return 16'($urandom_range(0, 6000) - 3000);
			default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		endcase
	endfunction

	function automatic logic [31:0] next_time();
		case ($urandom_range(0, 99))
			0, 1, 2: return now_ts;
			3, 4, 5, 6: return $urandom();
			default: return now_ts + $urandom_range(0, 1 << 18);
		endcase
	endfunction

	function automatic can_frame_t noise_frame();
		can_frame_t f;
		f.id = $urandom_range(0, 1) ? 29'($urandom())
			: ($urandom_range(0, 1) ? dwo_pkg::ID_LEFT : dwo_pkg::ID_RIGHT);
		f.ext = 1'($urandom_range(0, 1));
		f.rem = 1'($urandom_range(0, 1));
		f.err = 0;
		f.dlc = 4'($urandom_range(0, 8));
		f.lo = 8'($urandom());
		f.hi = 8'($urandom());
		f.ts = $urandom();
		return f;
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
		if (arst_n && out_valid && !out_stall) begin
			if (pose_q.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose transaction at %0t", $realtime);
			end else begin
				pose_t e, a;
				e = pose_q.pop_front();
				a = {distance_travelled, angular_rate, linear_speed, heading,
					odom_y, odom_x};
				poses_checked++;
				for (int i = 0; i < 6; i++)
					if (a[i] !== e[i]) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("%s mismatch: expected %0d got %0d", field_name[i],
								signed'(e[i]), signed'(a[i]));
					end
			end
		end
	end

	task automatic test_directed_frames;
		can_frame_t f;
		// both wheels at time zero: zero mean interval
		send_frame(wheel_frame(1, 16'd100, 32'd0));
		send_frame(wheel_frame(0, 16'd100, 32'd0));
		// extremes and smallest magnitudes of rpm in both orders
		send_frame(wheel_frame(1, 16'h7FFF, 32'd1 << 20));
		send_frame(wheel_frame(0, 16'h8000, 32'd1 << 20));
		send_frame(wheel_frame(0, 16'hFFFF, 32'd3 << 20));
		send_frame(wheel_frame(1, 16'h0001, 32'd3 << 20));
		// frames that are ignored
		f = wheel_frame(1, 16'd500, 32'hFFFF_FFFF);
		f.rem = 1;
		send_frame(f);
		f = wheel_frame(1, 16'd500, 32'd5);
		f.ext = 1;
		send_frame(f);
		f = wheel_frame(1, 16'd500, 32'd5);
		f.id = 29'h1FFF_FFFF;
		send_frame(f);
		f = wheel_frame(1, 16'd500, 32'd5);
		f.dlc = 4'd7;
		send_frame(f);
		// second left frame while disarmed changes nothing
		send_frame(wheel_frame(1, 16'd2000, 32'd4 << 20));
		send_frame(wheel_frame(1, 16'h8000, 32'd9 << 20));
		send_frame(wheel_frame(0, 16'd2000, 32'd4 << 20));
		// timestamp wrap
		send_frame(wheel_frame(1, 16'hF000, 32'h0000_0100));
		send_frame(wheel_frame(0, 16'h0FFF, 32'hFFFF_FF00));
		now_ts = 32'd0;
	endtask

	task automatic test_config_extremes;
		set_config(24'd0, 24'd1, 16'd0);
		send_frame(wheel_frame(1, 16'h7FFF, 32'd100));
		send_frame(wheel_frame(0, 16'h8000, 32'd200));
		set_config(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		send_frame(wheel_frame(1, 16'h7FFF, 32'd1 << 24));
		send_frame(wheel_frame(0, 16'h0100, 32'd1 << 24));
		send_frame(wheel_frame(0, 16'h8000, 32'hFFFF_FFFF));
		send_frame(wheel_frame(1, 16'h0005, 32'h8000_0000));
		set_config(24'hFF_FFFF, 24'd1, 16'd0);
		send_frame(wheel_frame(1, 16'h1234, 32'h4000_0000));
		send_frame(wheel_frame(0, 16'hEDCC, 32'h2000_0000));
	endtask

	task automatic test_random_traffic(input int count);
		int n;
		bit left_first;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 70) begin
				left_first = 1'($urandom_range(0, 1));
				now_ts = next_time();
				send_frame(wheel_frame(left_first, random_rpm(), now_ts));
				if ($urandom_range(0, 9) == 0)
					send_frame(wheel_frame(left_first, random_rpm(), next_time()));
				now_ts = next_time();
				send_frame(wheel_frame(!left_first, random_rpm(), now_ts));
				n += 2;
			end else begin
				send_frame(noise_frame());
				n++;
			end
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	task automatic test_random_settings;
		logic [23:0] spr, iwb;
		logic [15:0] db;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 18 : (ph == 1 ? 58 : 0);
			recv_idle = ph == 0 ? 58 : (ph == 1 ? 18 : 0);
			for (int k = 0; k < 2; k++) begin
				spr = $urandom_range(0, 3) == 0 ? 24'($urandom())
					: 24'($urandom_range(20000, 1200000));
				iwb = $urandom_range(0, 3) == 0 ? 24'($urandom()) | 24'd1
					: 24'($urandom_range(1, 400000));
				db = $urandom_range(0, 3) == 0 ? 16'($urandom())
					: 16'($urandom_range(0, 3000));
				set_config(spr, iwb, db);
				test_random_traffic(190);
			end
		end
	endtask

	// error frame halts for good, so it runs last
	task automatic test_error_halt;
		can_frame_t f;
		drain();
		send_idle = 10;
		recv_idle = 30;
		f = noise_frame();
		f.err = 1;
		send_frame(f);
		send_frame(wheel_frame(1, 16'd700, 32'd10));
		send_frame(wheel_frame(0, 16'd700, 32'd20));
		test_random_traffic(20);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_config_extremes();
		test_random_settings();
		test_error_halt();
		drain();
		repeat (300) @(posedge clk);
		$display("sent %0d can frames over several register settings and idle mixes", frames_sent);
		$display("checked %0d pose updates, %0d mismatches", poses_checked, mismatches);
		if (!failed && pose_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/dwo_pkg.sv
design/dwo_cordic.sv
design/dwo_div.sv
design/differential_wheel_odometry_top.sv
design/dwo_checker.sv
dv/tb_differential_wheel_odometry_top.sv
